FILE: design/cfc_pkg.sv
// cfc_pkg: constants, register map and elaboration-time log table maths
// for the capacitance_from_charge block. No dependencies.
package cfc_pkg;

  localparam int LEVEL_W   = 10;
  localparam int TIME_W    = 16;
  localparam int REG_W     = 16;
  localparam int CAP_W     = 40;
  localparam int LOG_W     = 32;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int FRAC_BITS = 58;

  localparam int unsigned ADC_FULL_SCALE_DEF = 1023;

  localparam logic [REG_W-1:0] STRAY_CAP_RST  = 16'd2629;
  localparam logic [REG_W-1:0] PULLUP_RES_RST = 16'd3940;

  // 10^7, the scale from us/(0.01 kOhm) to 0.01 pF
  localparam logic [23:0] SCALE_10M = 24'd10000000;

  localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

  // register byte addresses
  localparam logic [APB_AW-1:0] ADDR_STRAY_CAP  = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_PULLUP_RES = 3'd4;

  // (a*b) >> FRAC_BITS
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[FRAC_BITS+63:FRAC_BITS];
  endfunction

  // floor(num / den), shift and subtract
  function automatic logic [63:0] fx_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = num;
    for (int i = 0; i < 64; i++) begin
      r = {r[63:0], q[63]};
      q = q << 1;
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(num * 2^FRAC_BITS / den), num < den
  function automatic logic [63:0] fx_frac(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] r;
    logic [63:0] q;
    r = num;
    q = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // ln((den+num)/(den-num)) by the atanh series
  function automatic logic [63:0] fx_atanh2(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] z;
    logic [63:0] zz;
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] k;
    z = fx_frac(num, den);
    zz = fx_mul(z, z);
    s = z;
    term = z;
    k = 64'd3;
    while (term != 0 && k < 64'd200) begin
      term = fx_mul(term, zz);
      s = s + fx_udiv(term, k);
      k = k + 64'd2;
    end
    return s << 1;
  endfunction

  // ln(a/b), a >= b >= 1
  function automatic logic [63:0] fx_ln_ratio(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] ln2);
    logic [63:0] bb;
    logic [63:0] k;
    bb = b;
    k = '0;
    while ((bb << 1) <= a) begin
      bb = bb << 1;
      k = k + 64'd1;
    end
    return k * ln2 + fx_atanh2(a - bb, a + bb);
  endfunction

  // Q16 of -ln(1 - v/full), rounded; zero at and above full scale
  function automatic logic [LOG_W-1:0] log_entry(input logic [63:0] full, input logic [63:0] v,
                                                 input logic [63:0] ln2);
    logic [63:0] x;
    if (v >= full) begin
      return '0;
    end
    x = fx_ln_ratio(full, full - v, ln2);
    x = (x + (64'd1 << (FRAC_BITS - 17))) >> (FRAC_BITS - 16);
    return x[LOG_W-1:0];
  endfunction

  function automatic logic [63:0] ln2_q58();
    return fx_atanh2(64'd1, 64'd3);
  endfunction

endpackage

FILE: design/cfc_meas_if.sv
// cfc_meas_if: valid/ready channel carrying one measurement beat.
// Depends on cfc_pkg.
interface cfc_meas_if
  import cfc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] first_level;
  logic [LEVEL_W-1:0] final_level;
  logic [TIME_W-1:0]  charge_time;

  modport source(output valid, first_level, final_level, charge_time, input ready);
  modport sink(input valid, first_level, final_level, charge_time, output ready);
endinterface

FILE: design/cfc_result_if.sv
// cfc_result_if: valid/ready channel carrying one result beat.
// Depends on cfc_pkg.
interface cfc_result_if
  import cfc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacitance;
  logic             rc_method;
  logic             saturated;

  modport source(output valid, capacitance, rc_method, saturated, input ready);
  modport sink(input valid, capacitance, rc_method, saturated, output ready);
endinterface

FILE: design/capacitance_from_charge.sv
// capacitance_from_charge: capacitance from ADC charge readings, pipelined.
// Depends on cfc_pkg, cfc_meas_if, cfc_result_if.
//
//  channel   dir  beat contents
//  meas      in   first_level, final_level, charge_time
//  result    out  capacitance, rc_method, saturated
//  apb       in   writes/reads parasitic_cap (0x0), pullup_res (0x4)
//
// One beat enters per cycle unless stalled; there are four front stages
// (decode, log ROM read, pull-up multiply, operand select), 40 restoring
// division steps (one quotient bit each) and the output register.
// rst clears all valid bits and loads the register reset values.
// The whole pipeline holds while a result waits unaccepted; nothing is lost.
module capacitance_from_charge
  import cfc_pkg::*;
#(
  parameter int unsigned ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  cfc_meas_if.sink           meas,
  cfc_result_if.source       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int AW  = $clog2(ADC_FULL_SCALE + 1);       // log ROM index
  localparam int CW  = (AW > LEVEL_W) ? AW : LEVEL_W;      // internal code width
  localparam int DNW = CW + REG_W;                         // divider-method numerator
  localparam int TNW = TIME_W + 24;                        // t * 10^7
  localparam int NW  = TNW + 16;                           // full numerator
  localparam int DW  = REG_W + LOG_W;                      // denominator
  localparam int RW  = DW + 1;                             // partial remainder
  localparam int QW  = CAP_W;                              // quotient bits
  localparam logic [CW-1:0] FULL = CW'(ADC_FULL_SCALE);
  localparam logic [CW-1:0] THR  = CW'(ADC_FULL_SCALE - ADC_FULL_SCALE / 42);

  typedef logic [LOG_W-1:0] rom_t [ADC_FULL_SCALE+1];

  function automatic rom_t build_rom();
    rom_t r;
    logic [63:0] ln2;
    ln2 = ln2_q58();
    for (int v = 0; v <= int'(ADC_FULL_SCALE); v++) begin
      r[v] = log_entry(64'(ADC_FULL_SCALE), 64'(v), ln2);
    end
    return r;
  endfunction

  localparam rom_t LOG_ROM = build_rom();

  // ---------------- configuration registers ----------------
  logic [REG_W-1:0] parasitic_cap;
  logic [REG_W-1:0] pullup_res;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      parasitic_cap <= STRAY_CAP_RST;
      pullup_res    <= PULLUP_RES_RST;
    end else if (cfg_wr) begin
      if (paddr == ADDR_STRAY_CAP)  parasitic_cap <= pwdata[REG_W-1:0];
      if (paddr == ADDR_PULLUP_RES) pullup_res    <= pwdata[REG_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_STRAY_CAP:  prdata = APB_DW'(parasitic_cap);
      ADDR_PULLUP_RES: prdata = APB_DW'(pullup_res);
      default:         prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // Single enable for every stage: move when the output slot is free or
  // being drained this cycle.
  logic advance;
  logic out_valid;
  assign advance    = !out_valid || result.ready;
  assign meas.ready = advance;

  // ---------------- stage A: decode ----------------
  logic [CW-1:0] first_w, final_w, final_c, v_w;
  always_comb begin
    first_w = CW'(meas.first_level);
    final_w = CW'(meas.final_level);
    final_c = (final_w > FULL) ? FULL : final_w;
    v_w     = FULL - final_c;
  end

  logic           a_valid, a_rc, a_zero;
  logic [AW-1:0]  a_v;
  logic [DNW-1:0] a_dnum;
  logic [CW-1:0]  a_dden;
  logic [TNW-1:0] a_tnum;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (advance) a_valid <= meas.valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_rc   <= !(first_w < THR);
      a_zero <= (final_c == '0);           // fully discharged: infinite log
      a_v    <= v_w[AW-1:0];
      a_dnum <= DNW'(first_w) * DNW'(parasitic_cap);
      a_dden <= FULL - first_w;
      a_tnum <= TNW'(meas.charge_time) * TNW'(SCALE_10M);
    end
  end

  // ---------------- stage B: log ROM read ----------------
  logic             b_valid, b_rc, b_zero;
  logic [DNW-1:0]   b_dnum;
  logic [CW-1:0]    b_dden;
  logic [TNW-1:0]   b_tnum;
  logic [LOG_W-1:0] b_log;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (advance) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_rc   <= a_rc;
      b_zero <= a_zero;
      b_dnum <= a_dnum;
      b_dden <= a_dden;
      b_tnum <= a_tnum;
      b_log  <= LOG_ROM[a_v];
    end
  end

  // ---------------- stage C: pull-up x log term ----------------
  logic           c_valid, c_rc, c_zero;
  logic [DNW-1:0] c_dnum;
  logic [CW-1:0]  c_dden;
  logic [TNW-1:0] c_tnum;
  logic [DW-1:0]  c_lden;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (advance) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_rc   <= b_rc;
      c_zero <= b_zero;
      c_dnum <= b_dnum;
      c_dden <= b_dden;
      c_tnum <= b_tnum;
      c_lden <= DW'(pullup_res) * DW'(b_log);
    end
  end

  // ---------------- stage D: operand select, overflow check ----------------
  logic [NW-1:0] sel_num;
  logic [DW-1:0] sel_den;
  logic          den_zero, ovf;
  always_comb begin
    sel_num  = c_rc ? {c_tnum, 16'd0} : NW'(c_dnum);
    sel_den  = c_rc ? c_lden : DW'(c_dden);
    den_zero = (sel_den == '0);
    // quotient needs more than QW bits iff the top numerator part >= den
    ovf      = DW'(sel_num[NW-1:QW]) >= sel_den;
  end

  logic          st_valid [0:QW];
  logic          st_rc    [0:QW];
  logic          st_byp   [0:QW];   // result fixed, division ignored
  logic          st_sat   [0:QW];
  logic [RW-1:0] st_rem   [0:QW];
  logic [QW-1:0] st_nq    [0:QW];   // numerator bits out at top, quotient in at bottom
  logic [DW-1:0] st_den   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) st_valid[0] <= 1'b0;
    else if (advance) st_valid[0] <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_rc[0]  <= c_rc;
      st_byp[0] <= c_rc && (c_zero || den_zero || ovf);
      st_sat[0] <= c_rc && !c_zero && (den_zero || ovf);
      st_rem[0] <= RW'(sel_num[NW-1:QW]);
      st_nq[0]  <= sel_num[QW-1:0];
      st_den[0] <= sel_den;
    end
  end

  // ---------------- restoring division, one bit per stage ----------------
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0] trial;
    logic          ge;
    always_comb begin
      trial = {st_rem[k][RW-2:0], st_nq[k][QW-1]};
      ge    = trial >= {1'b0, st_den[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) st_valid[k+1] <= 1'b0;
      else if (advance) st_valid[k+1] <= st_valid[k];
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st_rc[k+1]  <= st_rc[k];
        st_byp[k+1] <= st_byp[k];
        st_sat[k+1] <= st_sat[k];
        st_rem[k+1] <= ge ? (trial - {1'b0, st_den[k]}) : trial;
        st_nq[k+1]  <= {st_nq[k][QW-2:0], ge};
        st_den[k+1] <= st_den[k];
      end
    end
  end : g_div

  // ---------------- output register ----------------
  logic [CAP_W-1:0] out_cap;
  logic             out_rc, out_sat;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= st_valid[QW];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rc  <= st_rc[QW];
      out_sat <= st_sat[QW];
      if (st_byp[QW]) out_cap <= st_sat[QW] ? CAP_MAX : '0;
      else            out_cap <= st_nq[QW];
    end
  end

  assign result.valid       = out_valid;
  assign result.capacitance = out_cap;
  assign result.rc_method   = out_rc;
  assign result.saturated   = out_sat;

  // ---------------- assertions ----------------
  a_sat_only_rc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sat |-> out_rc)
    else $error("saturation flagged on divider method");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sat |-> out_cap == CAP_MAX)
    else $error("saturated result not at maximum");

  a_div_small: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rc |-> (out_cap >> DNW) == '0)
    else $error("divider-method result wider than its numerator");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_cap))
    else $error("stalled result changed");

endmodule
